// File: sv/vfc_pkg.sv
// Shared types, constants and the face corner table for the voxel face-cull mesher.
// No dependencies; the mesher unit imports this package.
`timescale 1ns / 1ps

package vfc_pkg;

    localparam int CHUNK_SIDE  = 16;
    localparam int CHUNK_TALL  = 256;
    localparam int STORE_DEPTH = CHUNK_SIDE * CHUNK_SIDE * CHUNK_TALL;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PADDR_W     = 4;
    localparam int FACES       = 6;
    localparam int VERTS       = 6;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_MESH  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_AIR    = 2'd0,
        REG_WATER  = 2'd1,
        REG_LEAVES = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    // Corner code: bit4 dx, bit3 dy, bit2 dz, bit1 u max, bit0 v max.
    localparam logic [4:0] CORNER_TAB [FACES][VERTS] = '{
        '{5'h00, 5'h12, 5'h17, 5'h00, 5'h17, 5'h05},
        '{5'h08, 5'h0D, 5'h1F, 5'h08, 5'h1F, 5'h1A},
        '{5'h02, 5'h0B, 5'h19, 5'h02, 5'h19, 5'h10},
        '{5'h04, 5'h16, 5'h1F, 5'h04, 5'h1F, 5'h0D},
        '{5'h00, 5'h06, 5'h0F, 5'h00, 5'h0F, 5'h09},
        '{5'h12, 5'h1B, 5'h1D, 5'h12, 5'h1D, 5'h14}
    };

    function automatic logic [4:0] corner_code(input logic [2:0] face,
                                               input logic [2:0] vert);
        logic [4:0] code;
        code = 5'h00;
        if (face < 3'(FACES) && vert < 3'(VERTS))
        begin
            code = CORNER_TAB[face][vert];
        end
        return code;
    endfunction

endpackage

// File: sv/vfc_if.sv
// Stream interfaces of the voxel face-cull mesher: command items in, vertices out.
// Depends on nothing but valid/ready signaling.
`timescale 1ns / 1ps

interface vfc_cmd_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [3:0] pos_x;
    logic [7:0] pos_y;
    logic [3:0] pos_z;
    logic [7:0] voxel_id;
    logic [3:0] sky_level;
    logic [3:0] lamp_level;

    modport source (output valid, operation, pos_x, pos_y, pos_z, voxel_id,
                    sky_level, lamp_level, input ready);
    modport sink   (input valid, operation, pos_x, pos_y, pos_z, voxel_id,
                    sky_level, lamp_level, output ready);
endinterface

interface vfc_vtx_if;
    logic       valid;
    logic       ready;
    logic [4:0] vert_x;
    logic [8:0] vert_y;
    logic [4:0] vert_z;
    logic [2:0] face_index;
    logic       u_is_max;
    logic       v_is_max;
    logic [7:0] face_block_id;
    logic [3:0] light_level;
    logic       translucent;
    logic       last;

    modport source (output valid, vert_x, vert_y, vert_z, face_index, u_is_max,
                    v_is_max, face_block_id, light_level, translucent, last,
                    input ready);
    modport sink   (input valid, vert_x, vert_y, vert_z, face_index, u_is_max,
                    v_is_max, face_block_id, light_level, translucent, last,
                    output ready);
endinterface

// File: sv/voxel_face_cull_mesher_unit.sv
// Voxel face-cull mesher: chunk store memory, face culling sequencer, APB registers.
// Depends on vfc_pkg and the stream interfaces in vfc_if.sv.
//
// A write item stores its voxel in the chunk memory at the transfer edge. A mesh
// item reads the voxel and its six neighbors through the one read port of that
// memory, one read per cycle, then takes a decision step, then emits one vertex
// per cycle while the vertex sink does not stall, six per emitted face. A new
// item is taken only once the previous mesh item has handed off its last vertex
// to the output register. An air voxel or a fully enclosed one gives no vertices.
`timescale 1ns / 1ps

module voxel_face_cull_mesher_unit
    import vfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    vfc_cmd_if.sink            cmd,
    vfc_vtx_if.source          vtx
);

    // Configuration registers
    logic [7:0] air_id_reg;
    logic [7:0] water_id_reg;
    logic [7:0] leaves_id_reg;
    logic       cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            air_id_reg    <= 8'd0;
            water_id_reg  <= 8'd1;
            leaves_id_reg <= 8'd2;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_AIR:    air_id_reg    <= pwdata[7:0];
                REG_WATER:  water_id_reg  <= pwdata[7:0];
                REG_LEAVES: leaves_id_reg <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_AIR:    prdata = {24'd0, air_id_reg};
            REG_WATER:  prdata = {24'd0, water_id_reg};
            REG_LEAVES: prdata = {24'd0, leaves_id_reg};
            default:    prdata = 32'd0;
        endcase
    end

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [3:0] x,
                                                    input logic [7:0] y,
                                                    input logic [3:0] z);
        return ADDR_W'((32'(y) * CHUNK_SIDE + 32'(z)) * CHUNK_SIDE + 32'(x));
    endfunction

    function automatic logic [2:0] lowest_face(input logic [FACES-1:0] mask);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = FACES - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // Sequencer registers
    state_t           state_reg, state_next;
    logic [3:0]       pos_x_reg, pos_x_next;
    logic [7:0]       pos_y_reg, pos_y_next;
    logic [3:0]       pos_z_reg, pos_z_next;
    logic [2:0]       fetch_cnt_reg, fetch_cnt_next;
    logic [7:0]       id_reg, id_next;
    logic [3:0]       light_reg, light_next;
    logic [FACES-1:0] nb_air_reg, nb_air_next;
    logic [FACES-1:0] mask_reg, mask_next;
    logic [2:0]       face_reg, face_next;
    logic [2:0]       vert_cnt_reg, vert_cnt_next;

    // Output register
    logic       vld_reg, vld_next;
    logic [4:0] vx_reg, vx_next;
    logic [8:0] vy_reg, vy_next;
    logic [4:0] vz_reg, vz_next;
    logic [2:0] vface_reg, vface_next;
    logic       umax_reg, umax_next;
    logic       vmax_reg, vmax_next;
    logic [7:0] vid_reg, vid_next;
    logic [3:0] vlight_reg, vlight_next;
    logic       vtrans_reg, vtrans_next;
    logic       vlast_reg, vlast_next;

    // Chunk store
    logic [15:0]       store_mem [STORE_DEPTH];
    logic [15:0]       rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              mem_we;

    logic             cmd_xfer;
    logic             in_range;
    logic [FACES-1:0] emit_mask;
    logic             slot_free;
    logic [4:0]       code;
    logic             translucent;
    logic [FACES-1:0] mask_left;
    logic [3:0]       rd_sky;
    logic [3:0]       rd_lamp;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign in_range  = (32'(cmd.pos_x) < CHUNK_SIDE) && (32'(cmd.pos_y) < CHUNK_TALL) &&
                       (32'(cmd.pos_z) < CHUNK_SIDE);

    assign mem_we  = cmd_xfer && in_range && (op_t'(cmd.operation) == OP_WRITE);
    assign wr_addr = cell_addr(cmd.pos_x, cmd.pos_y, cmd.pos_z);
    assign wr_data = {cmd.voxel_id, cmd.sky_level, cmd.lamp_level};

    // Read order: self, down, up, north, south, west, east
    always_comb
    begin
        case (fetch_cnt_reg)
            3'd1:    rd_addr = cell_addr(pos_x_reg, pos_y_reg - 8'd1, pos_z_reg);
            3'd2:    rd_addr = cell_addr(pos_x_reg, pos_y_reg + 8'd1, pos_z_reg);
            3'd3:    rd_addr = cell_addr(pos_x_reg, pos_y_reg, pos_z_reg - 4'd1);
            3'd4:    rd_addr = cell_addr(pos_x_reg, pos_y_reg, pos_z_reg + 4'd1);
            3'd5:    rd_addr = cell_addr(pos_x_reg - 4'd1, pos_y_reg, pos_z_reg);
            3'd6:    rd_addr = cell_addr(pos_x_reg + 4'd1, pos_y_reg, pos_z_reg);
            default: rd_addr = cell_addr(pos_x_reg, pos_y_reg, pos_z_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_sky  = rd_data_reg[7:4];
    assign rd_lamp = rd_data_reg[3:0];

    // Boundary faces always show; inner faces only against air
    assign emit_mask[0] = (pos_y_reg == 8'd0) || nb_air_reg[0];
    assign emit_mask[1] = (32'(pos_y_reg) == CHUNK_TALL - 1) || nb_air_reg[1];
    assign emit_mask[2] = (pos_z_reg == 4'd0) || nb_air_reg[2];
    assign emit_mask[3] = (32'(pos_z_reg) == CHUNK_SIDE - 1) || nb_air_reg[3];
    assign emit_mask[4] = (pos_x_reg == 4'd0) || nb_air_reg[4];
    assign emit_mask[5] = (32'(pos_x_reg) == CHUNK_SIDE - 1) || nb_air_reg[5];

    assign slot_free   = !vld_reg || vtx.ready;
    assign code        = corner_code(face_reg, vert_cnt_reg);
    assign translucent = (id_reg == water_id_reg) || (id_reg == leaves_id_reg);
    assign mask_left   = mask_reg & ~(FACES'(1) << face_reg);

    always_comb
    begin
        state_next     = state_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        fetch_cnt_next = fetch_cnt_reg;
        id_next        = id_reg;
        light_next     = light_reg;
        nb_air_next    = nb_air_reg;
        mask_next      = mask_reg;
        face_next      = face_reg;
        vert_cnt_next  = vert_cnt_reg;
        vld_next       = vld_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        vz_next        = vz_reg;
        vface_next     = vface_reg;
        umax_next      = umax_reg;
        vmax_next      = vmax_reg;
        vid_next       = vid_reg;
        vlight_next    = vlight_reg;
        vtrans_next    = vtrans_reg;
        vlast_next     = vlast_reg;

        if (vtx.ready)
        begin
            vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer && in_range && (op_t'(cmd.operation) == OP_MESH))
                begin
                    pos_x_next     = cmd.pos_x;
                    pos_y_next     = cmd.pos_y;
                    pos_z_next     = cmd.pos_z;
                    fetch_cnt_next = 3'd0;
                    state_next     = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // Data for read n-1 lands while read n is issued
                if (fetch_cnt_reg == 3'd1)
                begin
                    id_next    = rd_data_reg[15:8];
                    light_next = (rd_sky > rd_lamp) ? rd_sky : rd_lamp;
                end
                else if (fetch_cnt_reg != 3'd0)
                begin
                    nb_air_next[fetch_cnt_reg - 3'd2] = (rd_data_reg[15:8] == air_id_reg);
                end
                fetch_cnt_next = fetch_cnt_reg + 3'd1;
                if (fetch_cnt_reg == 3'd7)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                mask_next     = emit_mask;
                face_next     = lowest_face(emit_mask);
                vert_cnt_next = 3'd0;
                if (id_reg == air_id_reg || emit_mask == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    vld_next    = 1'b1;
                    vx_next     = 5'(pos_x_reg) + 5'(code[4]);
                    vy_next     = 9'(pos_y_reg) + 9'(code[3]);
                    vz_next     = 5'(pos_z_reg) + 5'(code[2]);
                    vface_next  = face_reg;
                    umax_next   = code[1];
                    vmax_next   = code[0];
                    vid_next    = id_reg;
                    vlight_next = light_reg;
                    vtrans_next = translucent;
                    vlast_next  = 1'b0;
                    if (vert_cnt_reg == 3'(VERTS - 1))
                    begin
                        // Advance to the next visible face, or finish
                        mask_next     = mask_left;
                        face_next     = lowest_face(mask_left);
                        vert_cnt_next = 3'd0;
                        if (mask_left == '0)
                        begin
                            vlast_next = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        vert_cnt_next = vert_cnt_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fetch_cnt_reg <= 3'd0;
            vld_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fetch_cnt_reg <= fetch_cnt_next;
            vld_reg       <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
        pos_z_reg    <= pos_z_next;
        id_reg       <= id_next;
        light_reg    <= light_next;
        nb_air_reg   <= nb_air_next;
        mask_reg     <= mask_next;
        face_reg     <= face_next;
        vert_cnt_reg <= vert_cnt_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        vz_reg       <= vz_next;
        vface_reg    <= vface_next;
        umax_reg     <= umax_next;
        vmax_reg     <= vmax_next;
        vid_reg      <= vid_next;
        vlight_reg   <= vlight_next;
        vtrans_reg   <= vtrans_next;
        vlast_reg    <= vlast_next;
    end

    assign vtx.valid         = vld_reg;
    assign vtx.vert_x        = vx_reg;
    assign vtx.vert_y        = vy_reg;
    assign vtx.vert_z        = vz_reg;
    assign vtx.face_index    = vface_reg;
    assign vtx.u_is_max      = umax_reg;
    assign vtx.v_is_max      = vmax_reg;
    assign vtx.face_block_id = vid_reg;
    assign vtx.light_level   = vlight_reg;
    assign vtx.translucent   = vtrans_reg;
    assign vtx.last          = vlast_reg;

endmodule
